FILE: rtl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg: shared types for the timer slot bank
// Transaction payloads, action codes and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int SLOT_W     = 4;
  localparam int VALUE_W    = 32;
  localparam int TICK_W     = 32;
  localparam int MAX_EVENTS = 16;
  localparam int EV_W       = $clog2(MAX_EVENTS + 1);

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_REARM = 2'd3
  } action_t;

  typedef struct packed {
    action_t              action;
    logic [SLOT_W-1:0]    slot;
    logic [VALUE_W-1:0]   period;
    logic [VALUE_W-1:0]   reload_value;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    expired_slot;
    logic [TICK_W-1:0]    tick_count;
    logic                 last;
  } out_item_t;

  // slot command broadcast to every cell
  typedef struct packed {
    action_t              op;
    logic [SLOT_W-1:0]    slot;
    logic [VALUE_W-1:0]   value;
  } cmd_t;

  // scan controller status seen by the top level
  typedef struct packed {
    logic                 busy;
    logic                 pend_valid;
    logic [EV_W-1:0]      ev_count;
  } scan_status_t;

endpackage

FILE: rtl/tsb_cell.sv
// ----------------------------------------------------------------------------
// tsb_cell: one stage of the slot ring
// Holds one slot's count and flags; shifts to its neighbor during a scan and
// applies start/stop/rearm commands addressed to its home position.
// ----------------------------------------------------------------------------
module tsb_cell #(
  parameter int COUNT_WIDTH = 32,
  parameter int CELL_ID     = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   shift,
  input  logic                   cmd_valid,
  input  tsb_pkg::cmd_t          cmd,
  input  logic [COUNT_WIDTH-1:0] nbr_cnt,
  input  logic                   nbr_run,
  input  logic                   nbr_wait,
  output logic [COUNT_WIDTH-1:0] cnt,
  output logic                   run,
  output logic                   wait_rearm
);

  logic [COUNT_WIDTH-1:0] cnt_r;
  logic                   run_r;
  logic                   wait_r;
  logic [COUNT_WIDTH-1:0] value;
  logic                   hit;

  assign value = COUNT_WIDTH'(cmd.value);
  assign hit   = cmd_valid && (32'(cmd.slot) == 32'(CELL_ID));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      wait_r <= 1'b0;
    end else if (shift) begin
      cnt_r  <= nbr_cnt;
      run_r  <= nbr_run;
      wait_r <= nbr_wait;
    end else if (hit) begin
      unique case (cmd.op)
        tsb_pkg::ACT_START: begin
          cnt_r  <= value;
          run_r  <= 1'b1;
          wait_r <= 1'b0;
        end
        tsb_pkg::ACT_STOP: begin
          cnt_r  <= '0;
          run_r  <= 1'b0;
          wait_r <= 1'b0;
        end
        tsb_pkg::ACT_REARM: begin
          if (run_r && wait_r) begin
            wait_r <= 1'b0;
            if (value != '0) begin
              cnt_r <= value;
            end else begin
              cnt_r <= '0;
              run_r <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt        = cnt_r;
  assign run        = run_r;
  assign wait_rearm = wait_r;

endmodule

FILE: rtl/tsb_scan.sv
// ----------------------------------------------------------------------------
// tsb_scan: tick scan controller at the head of the ring
// Shared decrementer and expiry test, event holding stage, output register
// and the free-running tick counter.
// ----------------------------------------------------------------------------
module tsb_scan #(
  parameter int SLOTS       = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tick_start,
  input  logic [COUNT_WIDTH-1:0] head_cnt,
  input  logic                   head_run,
  input  logic                   head_wait,
  output logic [COUNT_WIDTH-1:0] tail_cnt,
  output logic                   tail_run,
  output logic                   tail_wait,
  output logic                   shift,
  input  logic                   out_stall,
  output logic                   out_valid,
  output tsb_pkg::out_item_t     out_data,
  output tsb_pkg::scan_status_t  status
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t                       state_r;
  logic [IDXW-1:0]              idx_r;
  logic [tsb_pkg::EV_W-1:0]     ev_cnt_r;
  logic                         pend_valid_r;
  logic [IDXW-1:0]              pend_slot_r;
  logic [tsb_pkg::TICK_W-1:0]   tick_r;
  logic                         out_valid_r;
  tsb_pkg::out_item_t           out_data_r;

  logic in_scan, in_flush, elig, cnt_zero, cap_ok, expire;
  logic out_free, advance, push_mid, push_last;

  assign in_scan   = (state_r == ST_SCAN);
  assign in_flush  = (state_r == ST_FLUSH);
  assign elig      = head_run && !head_wait;
  assign cnt_zero  = (head_cnt == '0);
  assign cap_ok    = (ev_cnt_r < tsb_pkg::EV_W'(tsb_pkg::MAX_EVENTS));
  assign expire    = in_scan && elig && cnt_zero && cap_ok;
  assign out_free  = !out_valid_r || !out_stall;
  // a second event needs the output register to take the held one first
  assign advance   = in_scan && (!(expire && pend_valid_r) || out_free);
  assign push_mid  = advance && expire && pend_valid_r;
  assign push_last = in_flush && pend_valid_r && out_free;

  // shared decrementer; a capped zero slot passes through untouched
  assign tail_cnt  = (in_scan && elig && !cnt_zero) ? head_cnt - 1'b1 : head_cnt;
  assign tail_run  = head_run;
  assign tail_wait = head_wait || expire;
  assign shift     = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      ev_cnt_r     <= '0;
      pend_valid_r <= 1'b0;
      tick_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (tick_start) begin
            tick_r   <= tick_r + 1'b1;
            idx_r    <= '0;
            ev_cnt_r <= '0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (advance) begin
            idx_r <= idx_r + 1'b1;
            if (expire) begin
              pend_valid_r <= 1'b1;
              ev_cnt_r     <= ev_cnt_r + 1'b1;
            end
            if (idx_r == IDXW'(SLOTS - 1)) begin
              state_r <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            pend_valid_r <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance && expire) begin
      pend_slot_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_mid || push_last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_last) begin
      out_data_r.expired_slot <= tsb_pkg::SLOT_W'(pend_slot_r);
      out_data_r.tick_count   <= tick_r;
      out_data_r.last         <= push_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data          = out_data_r;
  assign status.busy       = (state_r != ST_IDLE);
  assign status.pend_valid = pend_valid_r;
  assign status.ev_count   = ev_cnt_r;

endmodule

FILE: rtl/timer_slot_bank.sv
// ----------------------------------------------------------------------------
// timer_slot_bank: bank of timer slots with a free-running tick counter
// Start/stop/rearm of slots and per-tick expiry events in ascending order.
// ----------------------------------------------------------------------------
// Usage: a tick transaction bumps the tick counter and then scans all SLOTS
// slots through one shared decrementer, one slot per cycle unless the
// result side stalls while an event is already held; the input stays
// stalled until the scan and its final flush are done. Each running slot
// that holds zero at its turn produces one expiry transaction (slot number,
// tick count after increment) and then freezes until rearmed; other running
// slots count down. Events leave in ascending slot order, at most 16 per
// tick, and the final event of a tick carries last. A rearm with zero frees
// the slot; a rearm of a slot that is not waiting, or any command to a slot
// at or above SLOTS, is ignored. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module timer_slot_bank #(
  parameter int SLOTS       = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsb_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tsb_pkg::out_item_t  out_data
);

  // Slot state lives in a ring of cells. Cell 0 is the head: during a scan
  // its contents pass through the scan unit into the last cell while every
  // other cell takes its upper neighbor. After SLOTS shifts each slot is back
  // in its home cell, so commands can address cells directly.

  logic [COUNT_WIDTH-1:0] cell_cnt  [SLOTS];
  logic                   cell_run  [SLOTS];
  logic                   cell_wait [SLOTS];

  logic [COUNT_WIDTH-1:0] tail_cnt;
  logic                   tail_run;
  logic                   tail_wait;
  logic                   shift;
  logic                   in_accept;
  logic                   tick_start;
  logic                   cmd_valid;
  tsb_pkg::cmd_t          cmd;
  tsb_pkg::scan_status_t  status;

  // no new transaction while a tick scan or its final flush is underway
  assign in_stall   = status.busy;
  assign in_accept  = in_valid && !in_stall;
  assign tick_start = in_accept && (in_data.action == tsb_pkg::ACT_TICK);
  assign cmd_valid  = in_accept && (in_data.action != tsb_pkg::ACT_TICK);

  // start loads period, rearm loads reload_value
  assign cmd.op    = in_data.action;
  assign cmd.slot  = in_data.slot;
  assign cmd.value = (in_data.action == tsb_pkg::ACT_START) ? in_data.period
                                                            : in_data.reload_value;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic [COUNT_WIDTH-1:0] nbr_cnt;
    logic                   nbr_run;
    logic                   nbr_wait;

    if (i == SLOTS - 1) begin : g_tail
      assign nbr_cnt  = tail_cnt;
      assign nbr_run  = tail_run;
      assign nbr_wait = tail_wait;
    end else begin : g_mid
      assign nbr_cnt  = cell_cnt[i+1];
      assign nbr_run  = cell_run[i+1];
      assign nbr_wait = cell_wait[i+1];
    end

    tsb_cell #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .CELL_ID     (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift      (shift),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .nbr_cnt    (nbr_cnt),
      .nbr_run    (nbr_run),
      .nbr_wait   (nbr_wait),
      .cnt        (cell_cnt[i]),
      .run        (cell_run[i]),
      .wait_rearm (cell_wait[i])
    );
  end

  tsb_scan #(
    .SLOTS       (SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_start (tick_start),
    .head_cnt   (cell_cnt[0]),
    .head_run   (cell_run[0]),
    .head_wait  (cell_wait[0]),
    .tail_cnt   (tail_cnt),
    .tail_run   (tail_run),
    .tail_wait  (tail_wait),
    .shift      (shift),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .status     (status)
  );

  // a result transaction only appears as a result of a tick scan
  a_out_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(status.busy))
    else $error("result transaction appeared outside a tick scan");

  // event cap per tick
  a_ev_cap: assert property (@(posedge clk) disable iff (!rst_n)
    status.ev_count <= tsb_pkg::EV_W'(tsb_pkg::MAX_EVENTS))
    else $error("expiry events exceeded per-tick limit");

  // an accepted tick always starts a scan
  a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tick_start |=> status.busy)
    else $error("accepted tick did not start a scan");

  // ring only moves while a scan is in progress
  a_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
    shift |-> (status.busy && !cmd_valid))
    else $error("slot ring shifted outside a scan");

endmodule
